### sv/rsr_pkg.sv
`default_nettype none

package rsr_pkg;

  localparam int DEPTH  = 16;
  localparam int KEY_W  = 32;
  localparam int SIZE_W = 5;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // best candidate seen so far along the chain
  typedef struct packed {
    logic valid;
    idx_t idx;
    key_t key;
  } cand_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_TAKE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t     sel;
    key_t     key;
    logic     frozen;
    logic     thaw;
    logic     ignore_frozen;
  } cell_cmd_t;

  typedef struct packed {
    logic full;
    logic frozen;
  } cell_stat_t;

endpackage

`default_nettype wire

### sv/rsr_ifs.sv
`default_nettype none

interface rsr_rec_if import rsr_pkg::*; ();
  logic valid;
  logic ready;
  key_t value;
  logic is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

interface rsr_res_if import rsr_pkg::*; ();
  logic valid;
  logic ready;
  key_t value_res;
  logic run_last;
  logic stream_last;

  modport source (output valid, output value_res, output run_last, output stream_last,
                  input ready);
  modport sink (input valid, input value_res, input run_last, input stream_last,
                output ready);
endinterface

interface rsr_cfg_if import rsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] buffer_size;

  modport source (output valid, output buffer_size, input ready);
  modport sink (input valid, input buffer_size, output ready);
endinterface

`default_nettype wire

### sv/rsr_cell.sv
`default_nettype none

module rsr_cell import rsr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire idx_t       slot_id,
  input  wire cell_cmd_t  cmd,
  input  wire cand_t      cand_in,
  output cand_t           cand_out,
  output cell_stat_t      stat
);

  key_t key;
  logic full;
  logic frozen;
  logic eligible;
  logic hit;

  assign hit      = (cmd.sel == slot_id);
  assign eligible = full && (!frozen || cmd.ignore_frozen);
  assign stat     = '{full: full, frozen: frozen};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && hit) begin
      key <= cmd.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full   <= 1'b0;
      frozen <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (hit) begin
            full   <= 1'b1;
            frozen <= cmd.frozen;
          end
        end
        OP_TAKE: begin
          if (hit) begin
            full   <= 1'b0;
            frozen <= 1'b0;
          end
        end
        default: ;
      endcase
      if (cmd.thaw) begin
        frozen <= 1'b0;
      end
    end
  end

  // strict less keeps the lower slot on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.valid <= 1'b0;
    end else if (eligible && (!cand_in.valid || key < cand_in.key)) begin
      cand_out <= '{valid: 1'b1, idx: slot_id, key: key};
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

`default_nettype wire

### sv/replacement_selection_runs.sv
// Channel  Dir  Handshake     Payload
// rec      in   valid/ready   value, is_last
// res      out  valid/ready   value_res, run_last, stream_last
// cfg      in   valid/ready   buffer_size (ready always high)
//
// A fill request loads one slot. A request that emits runs a minimum search: the search
// walks the row of DEPTH slot cells, one cell per cycle, after a slot update settles.
// After is_last, each drained result takes a further search of the row.
// A result held in the output register stalls only the next emit, not the search.
// Reset (rst, synchronous) empties all slots and sets buffer_size to 16.
`default_nettype none

module replacement_selection_runs import rsr_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  rsr_rec_if.sink   rec,
  rsr_res_if.source res,
  rsr_cfg_if.sink   cfg
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // the search waits for a slot update to reach the end of the row
  localparam logic [FILL_W-1:0] CNT_LAST = FILL_W'(DEPTH);

  state_t            state;
  logic [FILL_W-1:0] cnt;
  logic [FILL_W-1:0] fill_count;
  logic [SIZE_W-1:0] buffer_size;
  key_t              pend_key;
  logic              pend_last;
  logic              draining;
  logic              out_valid;
  key_t              out_key;
  logic              out_run;
  logic              out_stream;

  logic [FILL_W-1:0] size_eff;
  logic              fill_step;
  logic              out_free;
  logic              fire;
  logic              out_load;
  logic              any_active;
  logic              stream_end;
  logic [DEPTH-1:0]  full_vec;
  logic [DEPTH-1:0]  frozen_vec;
  logic [DEPTH-1:0]  full_after;
  logic [DEPTH-1:0]  frozen_after;
  cell_cmd_t         cmd;
  cand_t             chain [DEPTH+1];
  cell_stat_t        stat [DEPTH];
  cand_t             win;

  assign chain[0] = '0;
  assign win      = chain[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rsr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_id  (IDX_W'(g)),
      .cmd      (cmd),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1]),
      .stat     (stat[g])
    );
    assign full_vec[g]   = stat[g].full;
    assign frozen_vec[g] = stat[g].frozen;
  end

  always_comb begin
    if (buffer_size == '0) begin
      size_eff = FILL_W'(1);
    end else if ({{FILL_W{1'b0}}, buffer_size} > (FILL_W + SIZE_W)'(DEPTH)) begin
      size_eff = FILL_W'(DEPTH);
    end else begin
      size_eff = FILL_W'(buffer_size);
    end
  end

  assign any_active = |(full_vec & ~frozen_vec);
  assign fill_step  = (state == ST_IDLE) && rec.valid && (fill_count < size_eff);
  assign out_free   = !out_valid || res.ready;
  assign fire       = (state == ST_SEARCH) && (cnt == CNT_LAST) && out_free;
  assign out_load   = fire && win.valid;

  always_comb begin
    cmd = '{op: OP_NONE, sel: win.idx, key: pend_key, frozen: 1'b0, thaw: 1'b0,
            ignore_frozen: !any_active};
    if (fill_step) begin
      cmd.op  = OP_LOAD;
      cmd.sel = fill_count[IDX_W-1:0];
      cmd.key = rec.value;
    end else if (out_load) begin
      if (draining) begin
        cmd.op = OP_TAKE;
      end else begin
        cmd.op     = OP_LOAD;
        cmd.frozen = pend_key < win.key;
      end
    end

    full_after   = full_vec;
    frozen_after = frozen_vec;
    case (cmd.op)
      OP_LOAD: begin
        full_after[cmd.sel]   = 1'b1;
        frozen_after[cmd.sel] = cmd.frozen;
      end
      OP_TAKE: begin
        full_after[cmd.sel]   = 1'b0;
        frozen_after[cmd.sel] = 1'b0;
      end
      default: ;
    endcase

    // close the run when nothing active is left after this emit
    cmd.thaw   = out_load && !(|(full_after & ~frozen_after));
    stream_end = !(|full_after);
  end

  assign rec.ready       = (state == ST_IDLE);
  assign cfg.ready       = 1'b1;
  assign res.valid       = out_valid;
  assign res.value_res   = out_key;
  assign res.run_last    = out_run;
  assign res.stream_last = out_stream;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= SIZE_W'(16);
    end else if (cfg.valid) begin
      buffer_size <= cfg.buffer_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      fill_count <= '0;
      draining   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (rec.valid) begin
            pend_key  <= rec.value;
            pend_last <= rec.is_last;
            cnt       <= '0;
            if (fill_step) begin
              fill_count <= fill_count + FILL_W'(1);
              if (rec.is_last) begin
                draining <= 1'b1;
                state    <= ST_SEARCH;
              end
            end else begin
              draining <= 1'b0;
              state    <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (cnt != CNT_LAST) begin
            cnt <= cnt + FILL_W'(1);
          end else if (out_free) begin
            cnt <= '0;
            if (win.valid) begin
              out_valid  <= 1'b1;
              out_key    <= win.key;
              out_run    <= cmd.thaw;
              out_stream <= draining && stream_end;
            end
            if (!draining && pend_last) begin
              draining <= 1'b1;
            end else if (!draining || !win.valid || stream_end) begin
              state    <= ST_IDLE;
              draining <= 1'b0;
              if (draining) begin
                fill_count <= '0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_load_in_search: assert property (@(posedge clk) disable iff (rst)
    out_load |-> state == ST_SEARCH)
    else $error("result loaded outside a search");

  a_replace_finds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) && (cnt == CNT_LAST) && !draining |-> win.valid)
    else $error("replace search found no slot");

  a_run_end_thaws: assert property (@(posedge clk) disable iff (rst)
    out_load && cmd.thaw |=> frozen_vec == '0)
    else $error("slots still frozen after run end");

  a_stream_end_empty: assert property (@(posedge clk) disable iff (rst)
    out_load && draining && stream_end |=> fill_count == '0 && full_vec == '0)
    else $error("buffer not empty after stream end");

endmodule

`default_nettype wire
